FILE: rtl/core/tdpf_pkg.sv
`timescale 1ns / 1ps

package tdpf_pkg;

   // Status returned by the serial divider to its controller.
   typedef struct packed {
      logic done;
      logic rem_nonzero;
   } div_status_type;

   // The root iteration stops after four steps per operand bit plus this many.
   localparam int unsigned ROOT_CAP_EXTRA = 16;

   // First odd trial factor.
   localparam int unsigned FIRST_FACTOR = 3;

endpackage

FILE: rtl/core/trial_division_prime_filter.sv
`timescale 1ns / 1ps
// Each division runs in the shared bit-serial divider.
// Values below 3 or even are decided without a division; others take k root steps
// over both passes, then t trial factors (up to bound / 2).
// Throughput: one word at a time; the next word is taken once the result is registered.
// Reset (synchronous, active high) returns the controller to idle and drops rsp_valid.
module trial_division_prime_filter #(
   parameter int unsigned OPERAND_WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OPERAND_WIDTH-1:0] req_candidate,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_maybe_prime
);

   localparam int unsigned W        = OPERAND_WIDTH;
   localparam int unsigned ROOT_CAP = 4 * OPERAND_WIDTH + tdpf_pkg::ROOT_CAP_EXTRA;
   localparam int unsigned IW       = $clog2(ROOT_CAP + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_TRIAL,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic                      pass_ff, pass_in;
   logic [IW-1:0]             iter_ff, iter_in;
   logic [W-1:0]              n_ff, n_in;
   logic [W-1:0]              arg_ff, arg_in;
   logic [W-1:0]              x_ff, x_in;
   logic [W-1:0]              bound_ff, bound_in;
   logic [W-1:0]              f_ff, f_in;
   logic                      res_ff, res_in;
   logic                      start_ff, start_in;
   logic [W-1:0]              div_a_ff, div_a_in;
   logic [W-1:0]              div_b_ff, div_b_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_bit_ff, rsp_bit_in;

   logic [W-1:0]              quotient;
   tdpf_pkg::div_status_type  div_status;

   logic [W-1:0]              q_ceil;
   logic [W-1:0]              x_step;
   logic [W-1:0]              x_next;
   logic                      step_carry;
   logic [IW-1:0]             iter_next;
   logic [W:0]                f_next;

   tdpf_div #(
      .OPERAND_WIDTH (W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (div_a_ff),
      .divisor  (div_b_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   // New root estimate: floor((x + ceil(arg / x) + 1) / 2) without a wide sum.
   assign q_ceil     = quotient + W'(div_status.rem_nonzero);
   assign step_carry = (2'(x_ff[0]) + 2'(q_ceil[0]) + 2'd1) >= 2'd2;
   assign x_step     = (x_ff >> 1) + (q_ceil >> 1) + W'(step_carry);
   assign x_next     = (x_step == '0) ? W'(1) : x_step;
   assign iter_next  = iter_ff + IW'(1);
   assign f_next     = {1'b0, f_ff} + (W+1)'(2);

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      iter_in      = iter_ff;
      n_in         = n_ff;
      arg_in       = arg_ff;
      x_in         = x_ff;
      bound_in     = bound_ff;
      f_in         = f_ff;
      res_in       = res_ff;
      start_in     = 1'b0;
      div_a_in     = div_a_ff;
      div_b_in     = div_b_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_bit_in   = rsp_bit_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in = req_candidate;
               if (req_candidate < W'(2)) begin
                  res_in   = 1'b0;
                  state_in = ST_DONE;
               end else if (req_candidate == W'(2)) begin
                  res_in   = 1'b1;
                  state_in = ST_DONE;
               end else if (!req_candidate[0]) begin
                  res_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  pass_in  = 1'b0;
                  iter_in  = '0;
                  arg_in   = req_candidate;
                  x_in     = req_candidate;
                  div_a_in = req_candidate;
                  div_b_in = req_candidate;
                  start_in = 1'b1;
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            if (div_status.done) begin
               x_in    = x_next;
               iter_in = iter_next;
               if (x_next != x_ff && iter_next < IW'(ROOT_CAP)) begin
                  div_a_in = arg_ff;
                  div_b_in = x_next;
                  start_in = 1'b1;
               end else if (!pass_ff) begin
                  // The square root estimate becomes the argument of the second pass.
                  pass_in  = 1'b1;
                  iter_in  = '0;
                  arg_in   = x_next;
                  div_a_in = x_next;
                  div_b_in = x_next;
                  start_in = 1'b1;
               end else begin
                  bound_in = x_next;
                  f_in     = W'(tdpf_pkg::FIRST_FACTOR);
                  if (x_next < W'(tdpf_pkg::FIRST_FACTOR)) begin
                     res_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     div_a_in = n_ff;
                     div_b_in = W'(tdpf_pkg::FIRST_FACTOR);
                     start_in = 1'b1;
                     state_in = ST_TRIAL;
                  end
               end
            end
         end
         ST_TRIAL: begin
            if (div_status.done) begin
               if (!div_status.rem_nonzero) begin
                  res_in   = 1'b0;
                  state_in = ST_DONE;
               end else if (f_next > {1'b0, bound_ff}) begin
                  res_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  f_in     = f_next[W-1:0];
                  div_a_in = n_ff;
                  div_b_in = f_next[W-1:0];
                  start_in = 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pass_ff    <= pass_in;
      iter_ff    <= iter_in;
      n_ff       <= n_in;
      arg_ff     <= arg_in;
      x_ff       <= x_in;
      bound_ff   <= bound_in;
      f_ff       <= f_in;
      res_ff     <= res_in;
      div_a_ff   <= div_a_in;
      div_b_ff   <= div_b_in;
      rsp_bit_ff <= rsp_bit_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_maybe_prime = rsp_bit_ff;

endmodule

FILE: rtl/core/tdpf_div.sv
`timescale 1ns / 1ps

// Restoring divider that produces one quotient bit per cycle.
module tdpf_div #(
   parameter int unsigned OPERAND_WIDTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [OPERAND_WIDTH-1:0]     dividend,
   input  logic [OPERAND_WIDTH-1:0]     divisor,
   output logic [OPERAND_WIDTH-1:0]     quotient,
   output tdpf_pkg::div_status_type     status
);

   localparam int unsigned CW = $clog2(OPERAND_WIDTH + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [OPERAND_WIDTH-1:0] rem_ff, rem_in;
   logic [OPERAND_WIDTH-1:0] quo_ff, quo_in;
   logic [OPERAND_WIDTH-1:0] dvs_ff, dvs_in;
   logic [OPERAND_WIDTH:0]   trial;
   logic [OPERAND_WIDTH:0]   diff;

   // The partial remainder takes the next dividend bit from the top of the
   // quotient shift register, which fills with quotient bits from below.
   assign trial = {rem_ff, quo_ff[OPERAND_WIDTH-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(OPERAND_WIDTH);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (diff[OPERAND_WIDTH] == 1'b0) begin
            rem_in = diff[OPERAND_WIDTH-1:0];
            quo_in = {quo_ff[OPERAND_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[OPERAND_WIDTH-1:0];
            quo_in = {quo_ff[OPERAND_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient           = quo_ff;
   assign status.done        = done_ff;
   assign status.rem_nonzero = (rem_ff != '0);

endmodule
